>>> design/ecpa_pkg.sv
// ----------------------------------------------------------------------------
// ecpa_pkg
// Shared constants and types of the prime field point adder.
// ----------------------------------------------------------------------------
package ecpa_pkg;

    localparam int FIELD_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CURVE_A = 1'b1;

    localparam logic [15:0] MODULUS_RESET = 16'd7;
    localparam logic [15:0] CURVE_A_RESET = 16'd0;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch inputs, a, one and zero
        OP_MUL,       // t = sa * sb mod m, serial
        OP_ADD,       // t = sa + sb mod m
        OP_SUB,       // t = sa - sb mod m
        OP_MOVE       // t = sa, less m once if sa >= m
    } t_op;

    // Register file selectors.
    typedef enum logic [3:0] {
        SEL_PX, SEL_PY, SEL_QX, SEL_QY, SEL_A, SEL_T0, SEL_T1, SEL_T2,
        SEL_LAM, SEL_RX, SEL_ONE, SEL_ZERO, SEL_RY
    } t_sel;

    // Source of the result item.
    typedef enum logic [1:0] {
        RES_ZERO, RES_Q, RES_P, RES_SUM
    } t_res;

    typedef struct packed {
        logic start;
        t_op  op;
        t_sel sa;
        t_sel sb;
        t_sel dst;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic p_inf;
        logic q_inf;
        logic x_eq;
        logic y_eq;
        logic py_zero;
        logic small_mod;
    } t_status;

endpackage

>>> design/ecpa_datapath.sv
// ----------------------------------------------------------------------------
// ecpa_datapath
// Register file, one shared bit-serial modular multiplier and add/sub/move.
// ----------------------------------------------------------------------------
module ecpa_datapath #(
    parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ecpa_pkg::t_cmd        i_cmd,
    input  logic [FIELD_BITS-1:0] i_modulus,
    input  logic [FIELD_BITS-1:0] i_curve_a,
    input  logic [FIELD_BITS-1:0] i_p_x,
    input  logic [FIELD_BITS-1:0] i_p_y,
    input  logic [FIELD_BITS-1:0] i_q_x,
    input  logic [FIELD_BITS-1:0] i_q_y,
    output ecpa_pkg::t_status     o_status,
    output logic [FIELD_BITS-1:0] o_px,
    output logic [FIELD_BITS-1:0] o_py,
    output logic [FIELD_BITS-1:0] o_qx,
    output logic [FIELD_BITS-1:0] o_qy,
    output logic [FIELD_BITS-1:0] o_rx,
    output logic [FIELD_BITS-1:0] o_ry
);

    localparam int W  = FIELD_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int NR = 13;

    logic [W-1:0]  r_rf [NR];
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    ecpa_pkg::t_sel r_dst;
    logic [W-1:0]  va, vb, m, d, s;

    assign m = i_modulus;

    // Mod add of two reduced values.
    function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] mm);
        logic [W:0] sm;
        sm = {1'b0, x} + {1'b0, y};
        if (sm >= {1'b0, mm}) sm = sm - {1'b0, mm};
        return sm[W-1:0];
    endfunction

    assign va = r_rf[i_cmd.sa];
    assign vb = r_rf[i_cmd.sb];
    assign d  = addm(r_acc, r_acc, m);
    assign s  = addm(d, r_x, m);

    always_comb begin
        n_acc = r_y[W-1] ? s : d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (r_busy) begin
                r_acc <= n_acc;
                r_y   <= {r_y[W-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_rf[r_dst] <= n_acc;
                    r_busy      <= 1'b0;
                end
            end else if (i_cmd.start) begin
                case (i_cmd.op)
                    ecpa_pkg::OP_LOAD: begin
                        r_rf[ecpa_pkg::SEL_PX]   <= i_p_x;
                        r_rf[ecpa_pkg::SEL_PY]   <= i_p_y;
                        r_rf[ecpa_pkg::SEL_QX]   <= i_q_x;
                        r_rf[ecpa_pkg::SEL_QY]   <= i_q_y;
                        r_rf[ecpa_pkg::SEL_A]    <= i_curve_a;
                        r_rf[ecpa_pkg::SEL_ONE]  <= W'(1);
                        r_rf[ecpa_pkg::SEL_ZERO] <= '0;
                    end
                    ecpa_pkg::OP_MUL: begin
                        // The first operand must be reduced; the second may be
                        // any value, so one times a raw value reduces it.
                        r_x    <= va;
                        r_y    <= vb;
                        r_acc  <= '0;
                        r_cnt  <= CW'(W);
                        r_dst  <= i_cmd.dst;
                        r_busy <= 1'b1;
                    end
                    ecpa_pkg::OP_ADD: r_rf[i_cmd.dst] <= addm(va, vb, m);
                    ecpa_pkg::OP_SUB: r_rf[i_cmd.dst] <= (va >= vb) ? va - vb : va + (m - vb);
                    ecpa_pkg::OP_MOVE: r_rf[i_cmd.dst] <=
                        (va >= m) ? va - m : va;
                    default: ;
                endcase
            end
        end
    end

    assign o_status.busy      = r_busy;
    assign o_status.p_inf     = (r_rf[ecpa_pkg::SEL_PX] == '0) && (r_rf[ecpa_pkg::SEL_PY] == '0);
    assign o_status.q_inf     = (r_rf[ecpa_pkg::SEL_QX] == '0) && (r_rf[ecpa_pkg::SEL_QY] == '0);
    assign o_status.x_eq      = r_rf[ecpa_pkg::SEL_PX] == r_rf[ecpa_pkg::SEL_QX];
    assign o_status.y_eq      = r_rf[ecpa_pkg::SEL_PY] == r_rf[ecpa_pkg::SEL_QY];
    assign o_status.py_zero   = r_rf[ecpa_pkg::SEL_PY] == '0;
    assign o_status.small_mod = m < W'(3);
    assign o_px = r_rf[ecpa_pkg::SEL_PX];
    assign o_py = r_rf[ecpa_pkg::SEL_PY];
    assign o_qx = r_rf[ecpa_pkg::SEL_QX];
    assign o_qy = r_rf[ecpa_pkg::SEL_QY];
    assign o_rx = r_rf[ecpa_pkg::SEL_RX];
    assign o_ry = r_rf[ecpa_pkg::SEL_RY];

endmodule

>>> design/ecpa_ctrl.sv
// ----------------------------------------------------------------------------
// ecpa_ctrl
// Sequencer issuing field operations for one point addition.
// ----------------------------------------------------------------------------
module ecpa_ctrl #(
    parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  logic [FIELD_BITS-1:0] i_modulus,
    input  ecpa_pkg::t_status     i_status,
    output ecpa_pkg::t_cmd        o_cmd,
    output ecpa_pkg::t_res        o_res_sel
);

    localparam int W  = FIELD_BITS;
    localparam int CW = $clog2(W);

    typedef enum logic [4:0] {
        S_IDLE, S_RED0, S_RED1, S_RED2, S_RED3, S_RED4, S_CLS,
        S_D0, S_D1, S_D2, S_D3, S_D4, S_C0, S_C1,
        S_E0, S_E1, S_E2, S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_DONE
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_bit;
    logic           r_sq;
    logic           r_out_valid;
    ecpa_pkg::t_res r_res_sel;
    logic [W-1:0]   e;
    logic           take;

    assign e = i_modulus - W'(2);
    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_res_sel   = r_res_sel;
    assign take        = r_out_valid && !i_out_stall;

    function automatic ecpa_pkg::t_cmd mk(input ecpa_pkg::t_op op, input ecpa_pkg::t_sel a,
                                          input ecpa_pkg::t_sel b, input ecpa_pkg::t_sel dd);
        ecpa_pkg::t_cmd c;
        c.start = 1'b1; c.op = op; c.sa = a; c.sb = b; c.dst = dd;
        return c;
    endfunction

    always_comb begin
        o_cmd = '0;
        if (!i_status.busy) begin
            case (r_state)
                S_IDLE:  if (i_in_valid && !r_out_valid)
                    o_cmd = mk(ecpa_pkg::OP_LOAD, ecpa_pkg::SEL_PX, ecpa_pkg::SEL_PX,
                               ecpa_pkg::SEL_PX);
                S_RED0: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_ONE, ecpa_pkg::SEL_PX,
                                   ecpa_pkg::SEL_PX);
                S_RED1: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_ONE, ecpa_pkg::SEL_PY,
                                   ecpa_pkg::SEL_PY);
                S_RED2: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_ONE, ecpa_pkg::SEL_QX,
                                   ecpa_pkg::SEL_QX);
                S_RED3: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_ONE, ecpa_pkg::SEL_QY,
                                   ecpa_pkg::SEL_QY);
                S_RED4: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_ONE, ecpa_pkg::SEL_A,
                                   ecpa_pkg::SEL_A);
                S_D0: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_PX, ecpa_pkg::SEL_PX,
                                 ecpa_pkg::SEL_T0);
                S_D1: o_cmd = mk(ecpa_pkg::OP_ADD, ecpa_pkg::SEL_T0, ecpa_pkg::SEL_T0,
                                 ecpa_pkg::SEL_T1);
                S_D2: o_cmd = mk(ecpa_pkg::OP_ADD, ecpa_pkg::SEL_T1, ecpa_pkg::SEL_T0,
                                 ecpa_pkg::SEL_T1);
                S_D3: o_cmd = mk(ecpa_pkg::OP_ADD, ecpa_pkg::SEL_T1, ecpa_pkg::SEL_A,
                                 ecpa_pkg::SEL_T1);
                S_D4: o_cmd = mk(ecpa_pkg::OP_ADD, ecpa_pkg::SEL_PY, ecpa_pkg::SEL_PY,
                                 ecpa_pkg::SEL_T0);
                S_C0: o_cmd = mk(ecpa_pkg::OP_SUB, ecpa_pkg::SEL_QY, ecpa_pkg::SEL_PY,
                                 ecpa_pkg::SEL_T1);
                S_C1: o_cmd = mk(ecpa_pkg::OP_SUB, ecpa_pkg::SEL_QX, ecpa_pkg::SEL_PX,
                                 ecpa_pkg::SEL_T0);
                S_E0: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_ONE, ecpa_pkg::SEL_ONE,
                                 ecpa_pkg::SEL_T2);
                S_E1: o_cmd = r_sq ? mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_T2, ecpa_pkg::SEL_T2,
                                        ecpa_pkg::SEL_T2)
                                   : mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_T2, ecpa_pkg::SEL_T0,
                                        ecpa_pkg::SEL_T2);
                S_F0: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_T1, ecpa_pkg::SEL_T2,
                                 ecpa_pkg::SEL_LAM);
                S_F1: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_LAM, ecpa_pkg::SEL_LAM,
                                 ecpa_pkg::SEL_T0);
                S_F2: o_cmd = mk(ecpa_pkg::OP_SUB, ecpa_pkg::SEL_T0, ecpa_pkg::SEL_PX,
                                 ecpa_pkg::SEL_T0);
                S_F3: o_cmd = mk(ecpa_pkg::OP_SUB, ecpa_pkg::SEL_T0, ecpa_pkg::SEL_QX,
                                 ecpa_pkg::SEL_RX);
                S_F4: o_cmd = mk(ecpa_pkg::OP_SUB, ecpa_pkg::SEL_PX, ecpa_pkg::SEL_RX,
                                 ecpa_pkg::SEL_T0);
                S_F5: o_cmd = mk(ecpa_pkg::OP_MUL, ecpa_pkg::SEL_LAM, ecpa_pkg::SEL_T0,
                                 ecpa_pkg::SEL_T1);
                S_F6: o_cmd = mk(ecpa_pkg::OP_SUB, ecpa_pkg::SEL_T1, ecpa_pkg::SEL_PY,
                                 ecpa_pkg::SEL_RY);
                default: o_cmd = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_sq        <= 1'b1;
            r_out_valid <= 1'b0;
            r_res_sel   <= ecpa_pkg::RES_ZERO;
        end else begin
            if (take) r_out_valid <= 1'b0;
            if (!i_status.busy) begin
                case (r_state)
                    S_IDLE: if (i_in_valid && !r_out_valid) r_state <= S_RED0;
                    S_RED0: r_state <= S_RED1;
                    S_RED1: r_state <= S_RED2;
                    S_RED2: r_state <= S_RED3;
                    S_RED3: r_state <= S_RED4;
                    S_RED4: r_state <= S_CLS;
                    S_CLS: begin
                        if (i_status.small_mod) begin
                            r_res_sel <= ecpa_pkg::RES_ZERO; r_state <= S_DONE;
                        end else if (i_status.p_inf) begin
                            r_res_sel <= ecpa_pkg::RES_Q; r_state <= S_DONE;
                        end else if (i_status.q_inf) begin
                            r_res_sel <= ecpa_pkg::RES_P; r_state <= S_DONE;
                        end else if (i_status.x_eq) begin
                            if (!i_status.y_eq || i_status.py_zero) begin
                                r_res_sel <= ecpa_pkg::RES_ZERO; r_state <= S_DONE;
                            end else r_state <= S_D0;
                        end else r_state <= S_C0;
                    end
                    S_D0: r_state <= S_D1;
                    S_D1: r_state <= S_D2;
                    S_D2: r_state <= S_D3;
                    S_D3: r_state <= S_D4;
                    S_D4: r_state <= S_E0;
                    S_C0: r_state <= S_C1;
                    S_C1: r_state <= S_E0;
                    S_E0: begin
                        r_bit <= CW'(W - 1); r_sq <= 1'b1; r_state <= S_E1;
                    end
                    S_E1: begin
                        if (r_sq && e[r_bit]) r_sq <= 1'b0;
                        else begin
                            r_sq <= 1'b1;
                            if (r_bit == '0) r_state <= S_F0;
                            else r_bit <= r_bit - CW'(1);
                        end
                    end
                    S_F0: r_state <= S_F1;
                    S_F1: r_state <= S_F2;
                    S_F2: r_state <= S_F3;
                    S_F3: r_state <= S_F4;
                    S_F4: r_state <= S_F5;
                    S_F5: r_state <= S_F6;
                    S_F6: begin
                        r_res_sel <= ecpa_pkg::RES_SUM; r_state <= S_DONE;
                    end
                    S_DONE: begin
                        r_out_valid <= 1'b1; r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

endmodule

>>> design/ec_point_add_prime_field_core.sv
// ----------------------------------------------------------------------------
// ec_point_add_prime_field_core
// Affine point addition on y^2 = x^3 + a*x + b over a prime field.
// ----------------------------------------------------------------------------
// An item on the input channel carries two points P and Q; (0,0) stands for
// the point at infinity. The block accepts an item when i_in_valid is high
// and o_in_stall is low, and presents the sum on o_sum_x and o_sum_y with
// o_out_valid until a cycle with i_out_stall low takes it.
// All field products go through one bit-serial modular multiplier; the same
// unit first reduces the four coordinates and a. The inversion is a
// square-and-multiply power with FIELD_BITS squarings and one product per
// set bit of the modulus minus two. Items with a point at infinity, a result
// at infinity or a modulus below three skip the field arithmetic after the
// reductions and go straight to the result.
// One item is in work at a time; the next one can be accepted from the cycle
// after the previous result has left.
// Reset sets the modulus to 7 and a to 0 and empties the block.
// A stalled result holds its value; the input stays stalled meanwhile.
// The configuration port is always ready and may be written while idle.
// ----------------------------------------------------------------------------
module ec_point_add_prime_field_core #(
    parameter int FIELD_BITS = ecpa_pkg::FIELD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [FIELD_BITS-1:0]             i_p_x,
    input  logic [FIELD_BITS-1:0]             i_p_y,
    input  logic [FIELD_BITS-1:0]             i_q_x,
    input  logic [FIELD_BITS-1:0]             i_q_y,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [FIELD_BITS-1:0]             o_sum_x,
    output logic [FIELD_BITS-1:0]             o_sum_y,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ecpa_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [FIELD_BITS-1:0]             i_cfg_data
);

    logic [FIELD_BITS-1:0] r_modulus;
    logic [FIELD_BITS-1:0] r_curve_a;
    logic [FIELD_BITS-1:0] rx, ry;
    ecpa_pkg::t_cmd    cmd;
    ecpa_pkg::t_status st;
    ecpa_pkg::t_res    res_sel;
    logic [FIELD_BITS-1:0] px, py, qx, qy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= FIELD_BITS'(ecpa_pkg::MODULUS_RESET);
            r_curve_a <= FIELD_BITS'(ecpa_pkg::CURVE_A_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ecpa_pkg::REG_MODULUS: r_modulus <= i_cfg_data;
                ecpa_pkg::REG_CURVE_A: r_curve_a <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ecpa_ctrl #(.FIELD_BITS(FIELD_BITS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_modulus(r_modulus), .i_status(st), .o_cmd(cmd),
        .o_res_sel(res_sel)
    );

    ecpa_datapath #(.FIELD_BITS(FIELD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_modulus(r_modulus), .i_curve_a(r_curve_a),
        .i_p_x(i_p_x), .i_p_y(i_p_y), .i_q_x(i_q_x), .i_q_y(i_q_y),
        .o_status(st), .o_px(px), .o_py(py), .o_qx(qx), .o_qy(qy),
        .o_rx(rx), .o_ry(ry)
    );

    always_comb begin
        case (res_sel)
            ecpa_pkg::RES_Q:   begin o_sum_x = qx; o_sum_y = qy; end
            ecpa_pkg::RES_P:   begin o_sum_x = px; o_sum_y = py; end
            ecpa_pkg::RES_SUM: begin o_sum_x = rx; o_sum_y = ry; end
            default:           begin o_sum_x = '0; o_sum_y = '0; end
        endcase
    end

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_out_valid |-> o_in_stall;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while full");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sum_x));
    endproperty
    a_hold: assert property (p_hold) else $error("result changed");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point adder testbench
// Drives pairs of affine points into the prime field point adder under a
// series of moduli and curve coefficients, computes each expected sum with
// its own modular arithmetic, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FB = 16;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [FB-1:0] x;
        logic [FB-1:0] y;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [FB-1:0] i_p_x = '0, i_p_y = '0, i_q_x = '0, i_q_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [FB-1:0] o_sum_x, o_sum_y;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ecpa_pkg::CFG_IDX_BITS-1:0] i_cfg_index = ecpa_pkg::REG_MODULUS;
    logic [FB-1:0] i_cfg_data = '0;

    ec_point_add_prime_field_core #(.FIELD_BITS(FB)) DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [FB-1:0] field_mod = ecpa_pkg::MODULUS_RESET;
    logic [FB-1:0] coef_a = ecpa_pkg::CURVE_A_RESET;
    t_point sum_queue[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit random_stall_on = 1'b0;
    int hold_cycles = 0;
    bit long_stall = 1'b0;
    event long_stall_go;

    function automatic logic [63:0] fmul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        return (x * y) % m;
    endfunction

    function automatic logic [63:0] fpow(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 1 % m;
        for (int i = 15; i >= 0; i--) begin
            acc = fmul(acc, acc, m);
            if (e[i]) acc = fmul(acc, b, m);
        end
        return acc;
    endfunction

    function automatic t_point point_sum(t_point p, t_point q);
        logic [63:0] m, px, py, qx, qy, a, lam, num, den, rx, ry;
        t_point r;
        m = field_mod;
        r = '0;
        if (m < 3) return r;
        px = p.x % m; py = p.y % m; qx = q.x % m; qy = q.y % m;
        a = coef_a % m;
        if (px == 0 && py == 0) begin
            r.x = qx[FB-1:0]; r.y = qy[FB-1:0]; return r;
        end
        if (qx == 0 && qy == 0) begin
            r.x = px[FB-1:0]; r.y = py[FB-1:0]; return r;
        end
        if (px == qx) begin
            if (py != qy || py == 0) return r;
            num = (fmul(3 % m, fmul(px, px, m), m) + a) % m;
            den = (py + py) % m;
        end else begin
            num = (qy + m - py) % m;
            den = (qx + m - px) % m;
        end
        lam = fmul(num, fpow(den, m - 2, m), m);
        rx = (fmul(lam, lam, m) + 2 * m - px - qx) % m;
        ry = (fmul(lam, (px + m - rx) % m, m) + m - py) % m;
        r.x = rx[FB-1:0]; r.y = ry[FB-1:0];
        return r;
    endfunction

    // Long receiver hold-off, counted in its own process.
    always begin
        @(long_stall_go);
        long_stall = 1'b1;
        repeat (3000) @(posedge i_clk);
        long_stall = 1'b0;
    end

    // Result checker and receiver stall.
    always @(posedge i_clk) begin
        t_point exp_sum;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sum_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %0d,%0d", o_sum_x, o_sum_y);
            end else begin
                exp_sum = sum_queue.pop_front();
                if (exp_sum.x !== o_sum_x || exp_sum.y !== o_sum_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d,%0d got %0d,%0d",
                                 exp_sum.x, exp_sum.y, o_sum_x, o_sum_y);
                end
            end
        end
        if (long_stall) begin
            i_out_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (random_stall_on && $urandom_range(0, 19) == 0) begin
            hold_cycles <= $urandom_range(0, 11);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted input or taken result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Valid stays high after the accepting edge; the block stalls its input
    // right after an accept, and drain or a gap lowers it.
    task automatic send_pair(t_point p, t_point q, bit gaps);
        if (gaps && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_p_x <= p.x; i_p_y <= p.y; i_q_x <= q.x; i_q_y <= q.y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sum_queue.push_back(point_sum(p, q));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ecpa_pkg::CFG_IDX_BITS-1:0] idx, logic [FB-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == ecpa_pkg::REG_MODULUS) field_mod = val;
        else coef_a = val;
        @(posedge i_clk);
    endtask

    function automatic t_point mk(logic [FB-1:0] x, logic [FB-1:0] y);
        t_point r;
        r.x = x; r.y = y;
        return r;
    endfunction

    // Pick a coordinate mostly below the modulus, sometimes anywhere.
    function automatic logic [FB-1:0] rnd_coord();
        if ($urandom_range(0, 9) == 0) return FB'($urandom_range(0, 65535));
        if (field_mod == 0) return FB'($urandom);
        return FB'($urandom_range(0, field_mod - 1));
    endfunction

    task automatic test_special_cases;
        t_point g;
        write_reg(ecpa_pkg::REG_MODULUS, 16'd97);
        write_reg(ecpa_pkg::REG_CURVE_A, 16'd2);
        g = mk(16'd3, 16'd6);
        send_pair(mk(16'd0, 16'd0), g, 1'b0);
        send_pair(g, mk(16'd0, 16'd0), 1'b0);
        send_pair(mk(16'd0, 16'd0), mk(16'd0, 16'd0), 1'b0);
        send_pair(g, mk(16'd3, 16'd91), 1'b0);
        send_pair(g, g, 1'b0);
        send_pair(mk(16'd5, 16'd0), mk(16'd5, 16'd0), 1'b0);
        send_pair(g, mk(16'd80, 16'd10), 1'b0);
        send_pair(mk(16'd97, 16'd194), g, 1'b0);
        send_pair(mk(16'hFFFF, 16'hFFFF), mk(16'hFFFE, 16'h0001), 1'b0);
        send_pair(mk(16'hAAAA, 16'h5555), mk(16'h5555, 16'hAAAA), 1'b0);
        drain();
        write_reg(ecpa_pkg::REG_MODULUS, 16'd65521);
        write_reg(ecpa_pkg::REG_CURVE_A, 16'd65534);
        send_pair(mk(16'd65520, 16'd65520), mk(16'd1, 16'd2), 1'b0);
        send_pair(mk(16'd65520, 16'd65520), mk(16'd65520, 16'd65520), 1'b0);
        send_pair(mk(16'hFFFF, 16'h8000), mk(16'h7FFF, 16'hFFFE), 1'b0);
        drain();
        write_reg(ecpa_pkg::REG_MODULUS, 16'd3);
        write_reg(ecpa_pkg::REG_CURVE_A, 16'd0);
        send_pair(mk(16'd1, 16'd1), mk(16'd1, 16'd1), 1'b0);
        send_pair(mk(16'd1, 16'd2), mk(16'd2, 16'd1), 1'b0);
        drain();
        write_reg(ecpa_pkg::REG_MODULUS, 16'd2);
        send_pair(mk(16'd1, 16'd1), mk(16'd2, 16'd3), 1'b0);
        drain();
        write_reg(ecpa_pkg::REG_MODULUS, 16'd0);
        send_pair(mk(16'd5, 16'd5), mk(16'd6, 16'd6), 1'b0);
        drain();
        write_reg(ecpa_pkg::REG_MODULUS, 16'd65535);
        send_pair(mk(16'd100, 16'd200), mk(16'd300, 16'd400), 1'b0);
        send_pair(mk(16'd100, 16'd200), mk(16'd100, 16'd200), 1'b0);
        drain();
    endtask

    task automatic run_random_phase(logic [FB-1:0] m, logic [FB-1:0] a, int n, bit gaps);
        t_point p, q;
        write_reg(ecpa_pkg::REG_MODULUS, m);
        write_reg(ecpa_pkg::REG_CURVE_A, a);
        for (int i = 0; i < n; i++) begin
            p = mk(rnd_coord(), rnd_coord());
            case ($urandom_range(0, 5))
                0: q = p;
                1: q = mk(p.x, rnd_coord());
                2: q = mk(16'd0, 16'd0);
                default: q = mk(rnd_coord(), rnd_coord());
            endcase
            if ($urandom_range(0, 1)) send_pair(p, q, gaps);
            else send_pair(q, p, gaps);
        end
        drain();
    endtask

    task automatic test_backpressure;
        write_reg(ecpa_pkg::REG_MODULUS, 16'd251);
        write_reg(ecpa_pkg::REG_CURVE_A, 16'd7);
        @(posedge i_clk);
        -> long_stall_go;
        repeat (6) send_pair(mk(FB'($urandom_range(0, 250)), FB'($urandom_range(0, 250))),
                             mk(FB'($urandom_range(0, 250)), FB'($urandom_range(0, 250))),
                             1'b0);
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_pair(mk(16'd1, 16'd2), mk(16'd3, 16'd4), 1'b0);
        drain();
        random_stall_on = 1'b1;
        test_special_cases();
        test_backpressure();
        run_random_phase(16'd65521, 16'd3, 200, 1'b1);
        run_random_phase(16'd11, 16'd1, 120, 1'b1);
        run_random_phase(16'd65519, 16'd65534, 140, 1'b1);
        run_random_phase(16'd1021, 16'd0, 120, 1'b1);
        run_random_phase(16'hFFFF, 16'hFFFF, 60, 1'b1);
        random_stall_on = 1'b0;
        run_random_phase(16'd4099, 16'd123, 160, 1'b0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && sum_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
